>>> hdl/dti_pkg.sv
// Shared types and constants for the decision tree inference block.
package dti_pkg;

	typedef enum logic [2:0] {
		OP_WR_NODE = 3'd0,
		OP_WR_PROB = 3'd1,
		OP_WR_FEAT = 3'd2,
		OP_CLASSIFY = 3'd3,
		OP_CLASSIFY_PROB = 3'd4
	} opcode_t;

	// Table sizes follow the field widths of a request
	localparam int unsigned NODES = 1024;
	localparam int unsigned FEATURES = 256;
	localparam int unsigned CLASSES = 16;
	localparam int unsigned MAX_OUT = 16;
	localparam logic [1:0] REG_CLASS_COUNT = 2'd0;

	// One request as carried from front to back.
	typedef struct packed {
		logic [2:0] opcode;
		logic [9:0] node_addr;
		logic is_leaf;
		logic [7:0] feat_addr;
		logic [31:0] threshold;
		logic [9:0] left_child;
		logic [9:0] right_child;
		logic [3:0] leaf_class;
		logic [3:0] class_index;
		logic [15:0] probability;
		logic [31:0] feature_value;
	} req_t;

	// Back-end walker state.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECIDE,
		ST_PROB_RD,
		ST_EMIT
	} walk_state_t;

endpackage

>>> hdl/dti_front.sv
// Front end: registers requests into a short queue, filters unknown opcodes.
module dti_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  dti_pkg::req_t in_req,
	output logic q_valid,
	input  logic q_pop,
	output dti_pkg::req_t q_req
);
	import dti_pkg::*;

	localparam int unsigned DEPTH = 4;

	req_t buf_q [DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic push, keep;

	assign in_stall = (count_q == 3'(DEPTH));
	// unknown opcodes are dropped here; they change nothing
	assign keep = (in_req.opcode <= 3'(OP_CLASSIFY_PROB));
	assign push = in_valid && !in_stall && keep;
	assign q_valid = (count_q != 3'd0);
	assign q_req = buf_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= in_req;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + 3'(push) - 3'(q_pop);
		end
	end

endmodule

>>> hdl/dti_back.sv
// Back end: table writes, tree walk and result generation.
module dti_back #(
	parameter int unsigned WALK_LIMIT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  dti_pkg::req_t q_req,
	input  logic [4:0] class_count,
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] tree_class,
	output logic [3:0] result_class,
	output logic [15:0] class_probability,
	output logic last,
	output logic walk_error
);
	import dti_pkg::*;

	localparam int unsigned DW = $clog2(WALK_LIMIT + 1);
	localparam int unsigned NMAX = (CLASSES < MAX_OUT) ? CLASSES : MAX_OUT;

	// memories
	logic [39:0] test_mem [NODES];
	logic [24:0] link_mem [NODES];
	logic [15:0] prob_mem [NODES * CLASSES];
	logic [31:0] feat_mem [FEATURES];

	logic [39:0] test_rd;
	logic [24:0] link_rd;
	logic [15:0] prob_rd;
	logic [31:0] feat_rd;

	walk_state_t state_q, state_d;
	logic [9:0] node_q, node_d;
	logic [DW-1:0] steps_q, steps_d;
	logic prob_mode_q, prob_mode_d;
	logic err_q, err_d;
	logic [3:0] pclass_q, pclass_d;
	logic [4:0] j_q, j_d;
	logic [4:0] n_eff;
	logic [31:0] thr_s2;
	logic [9:0] left_s2, right_s2;
	logic out_valid_q;
	logic [3:0] out_pc_q, out_rc_q;
	logic [15:0] out_prob_q;
	logic out_last_q, out_err_q;
	logic emit;
	logic out_free;
	logic [13:0] prob_addr;
	logic [9:0] next_node;
	logic go_left;

	// effective result count
	always_comb begin
		n_eff = class_count;
		if (n_eff == 5'd0) n_eff = 5'd1;
		if (n_eff > 5'(NMAX)) n_eff = 5'(NMAX);
	end

	assign prob_addr = {node_q, j_q[3:0]};
	assign out_valid = out_valid_q;
	assign tree_class = out_pc_q;
	assign result_class = out_rc_q;
	assign class_probability = out_prob_q;
	assign last = out_last_q;
	assign walk_error = out_err_q;
	assign out_free = !out_valid_q || !out_stall;

	// table writes and registered reads; node address is the next node
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			unique case (opcode_t'(q_req.opcode))
				OP_WR_NODE: begin
					test_mem[q_req.node_addr] <= {q_req.feat_addr, q_req.threshold};
					link_mem[q_req.node_addr] <= {q_req.is_leaf,
						q_req.left_child, q_req.right_child, q_req.leaf_class};
				end
				OP_WR_PROB: prob_mem[{q_req.node_addr, q_req.class_index}]
					<= q_req.probability;
				OP_WR_FEAT: feat_mem[q_req.feat_addr] <= q_req.feature_value;
				default: ;
			endcase
		end
		test_rd <= test_mem[node_d];
		link_rd <= link_mem[node_d];
		prob_rd <= prob_mem[prob_addr];
	end

	// feature fetch uses the tested index from the node read
	always_ff @(posedge clk) begin
		feat_rd <= feat_mem[test_rd[39:32]];
		thr_s2 <= test_rd[31:0];
		left_s2 <= link_rd[23:14];
		right_s2 <= link_rd[13:4];
	end

	assign go_left = $signed(feat_rd) <= $signed(thr_s2);
	assign next_node = go_left ? left_s2 : right_s2;

	// walker control
	always_comb begin
		state_d = state_q;
		node_d = node_q;
		steps_d = steps_q;
		prob_mode_d = prob_mode_q;
		err_d = err_q;
		pclass_d = pclass_q;
		j_d = j_q;
		q_pop = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			ST_IDLE: if (q_valid) begin
				q_pop = 1'b1;
				if (q_req.opcode == 3'(OP_CLASSIFY) ||
						q_req.opcode == 3'(OP_CLASSIFY_PROB)) begin
					prob_mode_d = (q_req.opcode == 3'(OP_CLASSIFY_PROB));
					node_d = '0;
					steps_d = '0;
					err_d = 1'b0;
					j_d = '0;
					state_d = ST_FETCH;
				end
			end
			// node words valid now; feature read issued at this edge
			ST_FETCH: begin
				if (link_rd[24]) begin
					pclass_d = link_rd[3:0];
					state_d = prob_mode_q ? ST_PROB_RD : ST_EMIT;
				end else if (steps_q >= DW'(WALK_LIMIT)) begin
					err_d = 1'b1;
					pclass_d = '0;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			// feature and threshold valid; child goes straight to the read port
			ST_DECIDE: begin
				steps_d = steps_q + DW'(1);
				node_d = next_node;
				state_d = ST_FETCH;
			end
			ST_PROB_RD: state_d = ST_EMIT;
			ST_EMIT: if (out_free) begin
				emit = 1'b1;
				if (!prob_mode_q || j_q + 5'd1 >= n_eff) begin
					state_d = ST_IDLE;
				end else begin
					j_d = j_q + 5'd1;
					state_d = ST_PROB_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// walker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_q <= '0;
			steps_q <= '0;
			prob_mode_q <= 1'b0;
			err_q <= 1'b0;
			pclass_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			node_q <= node_d;
			steps_q <= steps_d;
			prob_mode_q <= prob_mode_d;
			err_q <= err_d;
			pclass_q <= pclass_d;
			j_q <= j_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pc_q <= pclass_q;
			out_rc_q <= prob_mode_q ? j_q[3:0] : 4'd0;
			out_prob_q <= (prob_mode_q && !err_q) ? prob_rd : 16'd0;
			out_last_q <= !prob_mode_q || (j_q + 5'd1 >= n_eff);
			out_err_q <= err_q;
		end
	end

endmodule

>>> hdl/decision_tree_inference_top.sv
// Top level of the decision tree inference block.
// Requests enter on in_valid/in_stall with one port per field. Opcodes 0..2
// load node entries, leaf probabilities and feature values; 3 classifies and
// returns one result, 4 returns class_count (clamped to 1..16) results with
// last on the final. Other opcodes are dropped. Results leave on
// out_valid/out_stall from an output register. A four-entry request queue
// sits between the input and the walker, so requests are taken while a
// result waits. A write request leaves the queue and updates its table.
// A walk handles each inner node by a node read, then a feature read and
// compare. With probabilities, each result waits for its probability read
// before it is registered. depth is capped by WALK_LIMIT.
// Reset clears control state and sets class_count to 2; table contents are
// undefined until written. A stalled receiver holds the output register and
// the walker waits; the queue fills and then stalls the input.
// class_count is written over the APB port at address 0.
module decision_tree_inference_top #(
	parameter int unsigned WALK_LIMIT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] opcode,
	input  logic [9:0] node_addr,
	input  logic is_leaf,
	input  logic [7:0] feat_addr,
	input  logic signed [31:0] threshold,
	input  logic [9:0] left_child,
	input  logic [9:0] right_child,
	input  logic [3:0] leaf_class,
	input  logic [3:0] class_index,
	input  logic [15:0] probability,
	input  logic signed [31:0] feature_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] tree_class,
	output logic [3:0] result_class,
	output logic [15:0] class_probability,
	output logic last,
	output logic walk_error
);
	import dti_pkg::*;

	req_t in_req, q_req;
	logic q_valid, q_pop;
	logic [4:0] class_count_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_CLASS_COUNT) ? {27'd0, class_count_q} : 32'd0;

	// class_count register at byte address 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) class_count_q <= 5'd2;
		else if (psel && penable && pwrite && paddr == REG_CLASS_COUNT)
			class_count_q <= pwdata[4:0];
	end

	assign in_req = '{opcode: opcode, node_addr: node_addr, is_leaf: is_leaf,
		feat_addr: feat_addr, threshold: threshold, left_child: left_child,
		right_child: right_child, leaf_class: leaf_class, class_index: class_index,
		probability: probability, feature_value: feature_value};

	dti_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
	);

	dti_back #(
		.WALK_LIMIT(WALK_LIMIT)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
		.class_count(class_count_q), .out_valid(out_valid), .out_stall(out_stall),
		.tree_class(tree_class), .result_class(result_class),
		.class_probability(class_probability), .last(last), .walk_error(walk_error)
	);

endmodule
